FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Widths, calendar constants and the month length table for the day count
// to calendar date unit.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int unsigned DayW   = 16;     // input day count
  localparam int unsigned LeftW  = 17;     // day count plus one
  localparam int unsigned LenW   = 9;      // up to 366
  localparam int unsigned YOffW  = 8;      // years since base year
  localparam int unsigned MonW   = 4;
  localparam int unsigned DomW   = 5;

  localparam logic [LenW-1:0]  DaysPerYear  = 9'd365;
  // base year 1980: 80 within its century, century 19 gives 3 modulo 4
  localparam logic [6:0]       BaseYearMod100 = 7'd80;
  localparam logic [1:0]       BaseCentMod4   = 2'd3;
  // year 2000 lies 20 years after the base year
  localparam logic [YOffW-1:0] SplitOffset  = 8'd20;
  // base year minus 1900
  localparam logic [YOffW-1:0] OldOffset    = 8'd80;
  localparam logic [MonW-1:0]  MonthFeb     = 4'd1;
  localparam logic [MonW-1:0]  MonthDec     = 4'd11;

  // Compare/subtract unit result
  typedef struct packed {
    logic             fits;   // left <= len
    logic [LeftW-1:0] diff;   // left - len
  } sub_res_t;

  // Month length, zero-based month index, February lengthened in leap years
  function automatic logic [LenW-1:0] month_len(input logic [MonW-1:0] m,
                                                input logic leap);
    logic [LenW-1:0] len;
    unique case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 9'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 9'd30;
      4'd1:                                      len = leap ? 9'd29 : 9'd28;
      default:                                   len = 9'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/dcc_sub_unit.sv
// ----------------------------------------------------------------------------
// dcc_sub_unit
// Shared compare-and-subtract unit: tells whether the days left fit in the
// current year or month and gives the remainder if they do not.
// ----------------------------------------------------------------------------
module dcc_sub_unit import dcc_pkg::*; (
  input  logic [LeftW-1:0] left_i,
  input  logic [LenW-1:0]  len_i,
  output sub_res_t         res_o
);

  logic [LeftW-1:0] len_ext;

  assign len_ext    = {{(LeftW-LenW){1'b0}}, len_i};
  assign res_o.fits = (left_i <= len_ext);
  assign res_o.diff = left_i - len_ext;

endmodule

FILE: rtl/core/day_count_to_calendar_date_unit.sv
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_unit
// Converts a count of days since 1 January 1980 into year offset, month and
// day of month (Gregorian, full leap rule).
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The unit then
// steps one year per cycle through a single compare-and-subtract unit, then
// one month per cycle through the same unit; busy falls in the cycle the
// result is shown. The result is on its ports for exactly one cycle with
// done_o high and must be captured then, as the unit cannot be held off.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date_unit import dcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [DayW-1:0]  day_count_i,
  output logic             done_o,
  output logic [YOffW-1:0] year_offset_o,
  output logic [MonW-1:0]  month_number_o,
  output logic [DomW-1:0]  day_of_month_o
);

  typedef enum logic [1:0] {
    StIdle,
    StYear,
    StMonth
  } state_e;

  state_e           state_q;
  logic             done_q;
  logic [LeftW-1:0] left_q;
  logic [YOffW-1:0] yoff_q;      // years since base year
  logic [6:0]       ymod100_q;   // year modulo 100
  logic [1:0]       cent_q;      // century modulo 4
  logic             leap_q;      // leap flag of the found year
  logic [MonW-1:0]  mon_q;       // zero-based month
  logic [YOffW-1:0] yo_out_q;
  logic [MonW-1:0]  mon_out_q;
  logic [DomW-1:0]  dom_out_q;

  logic             leap_cur;
  logic [LenW-1:0]  len_sel;
  sub_res_t         sub_res;

  // Leap rule from the running counters; base year is a multiple of four
  assign leap_cur = ((yoff_q[1:0] == 2'd0) && (ymod100_q != 7'd0)) ||
                    ((ymod100_q == 7'd0) && (cent_q == 2'd0));

  // Operand select for the shared unit
  always_comb begin
    if (state_q == StYear) begin
      len_sel = DaysPerYear + {{(LenW-1){1'b0}}, leap_cur};
    end else begin
      len_sel = month_len(mon_q, leap_q);
    end
  end

  dcc_sub_unit u_sub (
    .left_i (left_q),
    .len_i  (len_sel),
    .res_o  (sub_res)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= StYear;
          end
        end
        StYear: begin
          if (sub_res.fits) begin
            state_q <= StMonth;
          end
        end
        StMonth: begin
          if (sub_res.fits || (mon_q == MonthDec)) begin
            state_q <= StIdle;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (start) begin
          left_q    <= {1'b0, day_count_i} + {{(LeftW-1){1'b0}}, 1'b1};
          yoff_q    <= '0;
          ymod100_q <= BaseYearMod100;
          cent_q    <= BaseCentMod4;
          mon_q     <= '0;
        end
      end
      StYear: begin
        if (sub_res.fits) begin
          leap_q <= leap_cur;
        end else begin
          left_q <= sub_res.diff;
          yoff_q <= yoff_q + 8'd1;
          if (ymod100_q == 7'd99) begin
            ymod100_q <= '0;
            cent_q    <= cent_q + 2'd1;
          end else begin
            ymod100_q <= ymod100_q + 7'd1;
          end
        end
      end
      StMonth: begin
        if (sub_res.fits || (mon_q == MonthDec)) begin
          yo_out_q  <= (yoff_q >= SplitOffset) ? (yoff_q - SplitOffset)
                                               : (yoff_q + OldOffset);
          mon_out_q <= mon_q + 4'd1;
          dom_out_q <= left_q[DomW-1:0];
        end else begin
          left_q <= sub_res.diff;
          mon_q  <= mon_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign busy           = (state_q != StIdle);
  assign done_o         = done_q;
  assign year_offset_o  = yo_out_q;
  assign month_number_o = mon_out_q;
  assign day_of_month_o = dom_out_q;

endmodule

FILE: rtl/core/dcc_checker.sv
// ----------------------------------------------------------------------------
// dcc_checker
// Port-level checks on the day count to calendar date unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcc_checker import dcc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [MonW-1:0]  month_number_o,
  input logic [DomW-1:0]  day_of_month_o
);

  // a taken request keeps the unit busy next cycle
  `ASSERT_NEXT(a_req_busy, clk_i, rst_ni, start && !busy, busy && !done_o)
  // a result is shown only once the unit has gone idle
  `ASSERT_IMPLY(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // the result strobe lasts one cycle
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  // results only follow a busy period
  `ASSERT_IMPLY(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))
  // whenever a result is shown, month is in 1..12 and day is nonzero
  `ASSERT_IMPLY(a_date_range, clk_i, rst_ni, done_o,
    (month_number_o >= 4'd1) && (month_number_o <= 4'd12) && (day_of_month_o != 5'd0))

endmodule

bind day_count_to_calendar_date_unit dcc_checker u_dcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .month_number_o (month_number_o),
  .day_of_month_o (day_of_month_o)
);
